// ===== hdl/b64c_pkg.sv =====
// Shared constants and character mapping functions for the base64 codec.
`default_nettype none

package b64c_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE       = 2'd0;
    localparam logic [1:0] CFG_LINE_BREAK = 2'd1;
    localparam logic [1:0] CFG_LINE_GRPS  = 2'd2;

    // Reset values of the configuration registers
    localparam logic       MODE_RESET       = 1'b0;
    localparam logic       LINE_BREAK_RESET = 1'b1;
    localparam logic [7:0] LINE_GRPS_RESET  = 8'd19;

    // Operating modes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Most results one request can cause
    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

    // Special characters
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] c;
        v8 = {2'b00, v};
        if (v8 < 8'd26)
            c = v8 + 8'd65;             // 'A'..'Z'
        else if (v8 < 8'd52)
            c = v8 + 8'd71;             // 'a'..'z'
        else if (v8 < 8'd62)
            c = v8 - 8'd4;              // '0'..'9'
        else if (v8 == 8'd62)
            c = 8'h2B;                  // '+'
        else
            c = 8'h2F;                  // '/'
        return c;
    endfunction

    // Alphabet character to 6-bit value; anything else reads as all ones
    function automatic logic [5:0] dec_char(input logic [7:0] c);
        logic [7:0] v;
        if (c == 8'h2F)
            v = 8'd63;
        else if (c == 8'h2B)
            v = 8'd62;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c + 8'd4;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c - 8'd71;
        else if (c >= 8'h41 && c <= 8'h5A)
            v = c - 8'd65;
        else
            v = 8'hFF;
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/base64_codec.sv =====
// Streaming base64 encoder/decoder with an output buffer that hands out one
// character or byte per cycle while out_ready is high. The first result of a
// request with results is valid in the cycle after acceptance.
// A request is taken in the same cycle the buffer hands out its last entry.
// Reset (rst_n low, asynchronous) empties the buffer, clears group state and
// loads the register defaults.
`default_nettype none

module base64_codec (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_in,
    input  wire logic       last_in,
    // output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_out,
    output logic            last_out
);

    localparam int unsigned N   = b64c_pkg::MAX_RESULTS;
    localparam int unsigned CW  = b64c_pkg::CNT_W;
    localparam int unsigned IW  = b64c_pkg::IDX_W;

    // Configuration registers
    logic       mode_reg;
    logic       line_break_reg;
    logic [7:0] line_groups_reg;

    // Stream state
    logic [1:0] group_pos_reg, group_pos_next;
    logic [5:0] held_reg, held_next;
    logic [7:0] groups_on_line_reg, groups_on_line_next;

    // Result buffer
    logic [7:0]    buf_reg [N];
    logic [7:0]    buf_next [N];
    logic [CW-1:0] count_reg, count_next;
    logic          last_flag_reg, last_flag_next;

    // Results of the current request
    logic [7:0]    res [N];
    logic [CW-1:0] res_cnt;

    logic          in_fire;
    logic          out_fire;
    logic [1:0]    enc_pos;
    logic [5:0]    dec_val;
    logic          group_done;
    logic [IW-1:0] lf_slot;
    logic [7:0]    groups_inc;
    logic          line_hit;
    logic          is_pad;
    logic          is_crlf;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg == '0) || ((count_reg == CW'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign data_out  = buf_reg[0];
    assign last_out  = last_flag_reg && (count_reg == CW'(1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= b64c_pkg::MODE_RESET;
            line_break_reg  <= b64c_pkg::LINE_BREAK_RESET;
            line_groups_reg <= b64c_pkg::LINE_GRPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                b64c_pkg::CFG_MODE:       mode_reg        <= cfg_data[0];
                b64c_pkg::CFG_LINE_BREAK: line_break_reg  <= cfg_data[0];
                b64c_pkg::CFG_LINE_GRPS:  line_groups_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared helpers: character classes, line counter
    assign is_pad     = (data_in == b64c_pkg::CHAR_PAD);
    assign is_crlf    = (data_in == b64c_pkg::CHAR_CR) || (data_in == b64c_pkg::CHAR_LF);
    assign dec_val    = b64c_pkg::dec_char(data_in);
    assign enc_pos    = (group_pos_reg == 2'd3) ? 2'd0 : group_pos_reg;
    assign groups_inc = groups_on_line_reg + 8'd1;
    assign line_hit   = (groups_inc == line_groups_reg);

    // Per-request result generation and next stream state
    always_comb
    begin
        for (int i = 0; i < N; i++)
            res[i] = b64c_pkg::CHAR_PAD;
        res_cnt             = '0;
        group_done          = 1'b0;
        lf_slot             = '0;
        group_pos_next      = group_pos_reg;
        held_next           = held_reg;
        groups_on_line_next = groups_on_line_reg;

        if (mode_reg == b64c_pkg::MODE_ENCODE)
        begin
            case (enc_pos)
                2'd0:
                begin
                    res[0]         = b64c_pkg::enc_char(data_in[7:2]);
                    res_cnt        = CW'(1);
                    held_next      = {4'b0000, data_in[1:0]};
                    group_pos_next = 2'd1;
                    if (last_in)
                    begin
                        res[1]     = b64c_pkg::enc_char({data_in[1:0], 4'b0000});
                        res_cnt    = CW'(4);
                        group_done = 1'b1;
                        lf_slot    = IW'(4);
                    end
                end
                2'd1:
                begin
                    res[0]         = b64c_pkg::enc_char({held_reg[1:0], data_in[7:4]});
                    res_cnt        = CW'(1);
                    held_next      = {2'b00, data_in[3:0]};
                    group_pos_next = 2'd2;
                    if (last_in)
                    begin
                        res[1]     = b64c_pkg::enc_char({data_in[3:0], 2'b00});
                        res_cnt    = CW'(3);
                        group_done = 1'b1;
                        lf_slot    = IW'(3);
                    end
                end
                default:
                begin
                    res[0]     = b64c_pkg::enc_char({held_reg[3:0], data_in[7:6]});
                    res[1]     = b64c_pkg::enc_char(data_in[5:0]);
                    res_cnt    = CW'(2);
                    held_next  = '0;
                    group_done = 1'b1;
                    lf_slot    = IW'(2);
                end
            endcase

            // Group completed: count it, maybe close the line
            if (group_done)
            begin
                group_pos_next      = 2'd0;
                groups_on_line_next = line_hit ? 8'd0 : groups_inc;
                if (line_hit && line_break_reg)
                begin
                    res[lf_slot] = b64c_pkg::CHAR_LF;
                    res_cnt      = res_cnt + CW'(1);
                end
            end
        end
        else
        begin
            case (group_pos_reg)
                2'd0:
                begin
                    if (!is_crlf)
                    begin
                        held_next      = dec_val;
                        group_pos_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    res[0]         = {held_reg, dec_val[5:4]};
                    res_cnt        = CW'(1);
                    held_next      = dec_val;
                    group_pos_next = 2'd2;
                end
                2'd2:
                begin
                    res[0]         = {held_reg[3:0], dec_val[5:2]};
                    res_cnt        = is_pad ? CW'(0) : CW'(1);
                    held_next      = dec_val;
                    group_pos_next = 2'd3;
                end
                default:
                begin
                    res[0]         = {held_reg[1:0], dec_val};
                    res_cnt        = is_pad ? CW'(0) : CW'(1);
                    held_next      = '0;
                    group_pos_next = 2'd0;
                end
            endcase
        end

        // Final request of a stream returns the group state to zero
        if (last_in)
        begin
            group_pos_next      = 2'd0;
            held_next           = '0;
            groups_on_line_next = 8'd0;
        end
    end

    // Output buffer: load on request, otherwise shift out one entry per cycle while out_ready is high
    always_comb
    begin
        for (int i = 0; i < N; i++)
            buf_next[i] = buf_reg[i];
        count_next     = count_reg;
        last_flag_next = last_flag_reg;
        if (in_fire)
        begin
            for (int i = 0; i < N; i++)
                buf_next[i] = res[i];
            count_next     = res_cnt;
            last_flag_next = last_in;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < N - 1; i++)
                buf_next[i] = buf_reg[i + 1];
            count_next = count_reg - CW'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
            buf_reg[i] <= buf_next[i];
    end

    // Control and stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            last_flag_reg      <= 1'b0;
            group_pos_reg      <= 2'd0;
            held_reg           <= '0;
            groups_on_line_reg <= 8'd0;
        end
        else
        begin
            count_reg     <= count_next;
            last_flag_reg <= last_flag_next;
            if (in_fire)
            begin
                group_pos_reg      <= group_pos_next;
                held_reg           <= held_next;
                groups_on_line_reg <= groups_on_line_next;
            end
        end
    end

    // Buffer never holds more than one request's results
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("result buffer count out of range");

    // A request with results shows a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (res_cnt != '0)) |=> out_valid)
        else $error("result missing after accepted request");

    // Stream state is cleared after a final request
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_in) |=> (group_pos_reg == 2'd0) && (held_reg == '0)
                                 && (groups_on_line_reg == 8'd0))
        else $error("stream state not cleared after last request");

    // Decoding yields at most one byte per request
    a_decode_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode_reg == b64c_pkg::MODE_DECODE)) |-> (res_cnt <= CW'(1)))
        else $error("decode produced more than one byte");

    // Handing out the final entry without a new request empties the buffer
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !in_fire && (count_reg == CW'(1))) |=> !out_valid)
        else $error("buffer not empty after final entry");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the base64 codec: directed table, random streams, scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ITEMS    = 25;
    localparam int RAND_ITEMS   = 230;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 120;
    localparam int HOLD_AFTER   = 60;
    localparam int STALL_LIMIT  = 2000;

    // One output symbol: character or decoded byte, plus end-of-stream flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } sym_t;

    // Directed table row: either a register write or one request
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [7:0]  d;
        logic        l;
        logic        typed;
        logic [2:0]  n;
        logic [39:0] e;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_in;
    logic       last_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] data_out;
    logic       last_out;

    // Predictor copy of registers and stream state
    logic       cfg_mode;
    logic       cfg_lf_en;
    logic [7:0] cfg_grps;
    logic [1:0] grp_pos;
    logic [7:0] held;
    logic [7:0] line_cnt;

    logic [7:0] b64_alpha [64];
    logic [7:0] b64_value [256];

    sym_t step_syms [$];
    sym_t due_syms [$];
    row_t dir_rows [30];

    int  miss_cnt;
    int  items_sent;
    int  stuck_cycles;
    bit  in_up;

    base64_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_in   (data_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .last_out  (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] pick_grps();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic row_t row_item(logic [7:0] d, logic l);
        row_t r;
        r   = '0;
        r.d = d;
        r.l = l;
        return r;
    endfunction

    function automatic row_t row_chk(logic [7:0] d, logic l, logic [2:0] n, logic [39:0] e);
        row_t r;
        r       = '0;
        r.d     = d;
        r.l     = l;
        r.typed = 1'b1;
        r.n     = n;
        r.e     = e;
        return r;
    endfunction

    function automatic row_t row_reg(logic [1:0] idx, logic [7:0] val);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.d      = val;
        return r;
    endfunction

    function automatic void put_sym(logic [7:0] c);
        sym_t s;
        s.data = c;
        s.last = 1'b0;
        step_syms.push_back(s);
    endfunction

    // A four-character group is complete: line counting and optional line feed
    function automatic void end_group();
        line_cnt = line_cnt + 8'd1;
        if (line_cnt == cfg_grps) begin
            line_cnt = 8'd0;
            if (cfg_lf_en)
                put_sym(b64c_pkg::CHAR_LF);
        end
        grp_pos = 2'd0;
    endfunction

    // Symbols one request produces; queued as expected when keep is set
    function automatic void predict_base64(logic [7:0] d, logic l, bit keep);
        logic [1:0] p;
        logic [5:0] v;
        sym_t       s;
        step_syms.delete();
        if (cfg_mode == b64c_pkg::MODE_ENCODE) begin
            // a decode position of 3 restarts the group
            p = (grp_pos == 2'd3) ? 2'd0 : grp_pos;
            case (p)
                2'd0:
                begin
                    put_sym(b64_alpha[d[7:2]]);
                    held    = {6'd0, d[1:0]};
                    grp_pos = 2'd1;
                    if (l) begin
                        put_sym(b64_alpha[{d[1:0], 4'd0}]);
                        put_sym(b64c_pkg::CHAR_PAD);
                        put_sym(b64c_pkg::CHAR_PAD);
                        end_group();
                    end
                end
                2'd1:
                begin
                    put_sym(b64_alpha[{held[1:0], d[7:4]}]);
                    held    = {4'd0, d[3:0]};
                    grp_pos = 2'd2;
                    if (l) begin
                        put_sym(b64_alpha[{d[3:0], 2'd0}]);
                        put_sym(b64c_pkg::CHAR_PAD);
                        end_group();
                    end
                end
                default:
                begin
                    put_sym(b64_alpha[{held[3:0], d[7:6]}]);
                    put_sym(b64_alpha[d[5:0]]);
                    held = 8'd0;
                    end_group();
                end
            endcase
        end else begin
            // characters outside the alphabet read as all ones
            v = b64_value[d][5:0];
            case (grp_pos)
                2'd0:
                begin
                    if (d != b64c_pkg::CHAR_CR && d != b64c_pkg::CHAR_LF) begin
                        held    = {2'd0, v};
                        grp_pos = 2'd1;
                    end
                end
                2'd1:
                begin
                    put_sym({held[5:0], v[5:4]});
                    held    = {2'd0, v};
                    grp_pos = 2'd2;
                end
                2'd2:
                begin
                    if (d != b64c_pkg::CHAR_PAD)
                        put_sym({held[3:0], v[5:2]});
                    held    = {2'd0, v};
                    grp_pos = 2'd3;
                end
                default:
                begin
                    if (d != b64c_pkg::CHAR_PAD)
                        put_sym({held[1:0], v});
                    held    = 8'd0;
                    grp_pos = 2'd0;
                end
            endcase
        end
        // end of stream: flag the final symbol, clear the stream state
        if (l) begin
            if (step_syms.size() > 0) begin
                s      = step_syms.pop_back();
                s.last = 1'b1;
                step_syms.push_back(s);
            end
            grp_pos  = 2'd0;
            held     = 8'd0;
            line_cnt = 8'd0;
        end
        if (keep)
            foreach (step_syms[k])
                due_syms.push_back(step_syms[k]);
    endfunction

    task automatic drop_in();
        if (in_up) begin
            in_valid <= 1'b0;
            in_up = 1'b0;
        end
    endtask

    task automatic pace(input bit quiet);
        int n;
        n = quiet ? 0 : pick_gap();
        if (n > 0) begin
            drop_in();
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one request and hold it until accepted
    task automatic send_item(input logic [7:0] d, input logic l, input bit typed,
                             input logic [2:0] n, input logic [39:0] e);
        sym_t s;
        int   k;
        if (!in_up) begin
            in_valid <= 1'b1;
            in_up = 1'b1;
        end
        data_in <= d;
        last_in <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_base64(d, l, !typed);
        // hand-typed expectations replace the predicted ones
        if (typed)
            for (k = 0; k < n; k++) begin
                s.data = e[39 - 8*k -: 8];
                s.last = l && (k == n - 1);
                due_syms.push_back(s);
            end
        items_sent++;
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drop_in();
        while (due_syms.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            b64c_pkg::CFG_MODE:       cfg_mode  = val[0];
            b64c_pkg::CFG_LINE_BREAK: cfg_lf_en = val[0];
            b64c_pkg::CFG_LINE_GRPS:  cfg_grps  = val;
            default: ;
        endcase
    endtask

    // Raw bytes, usually closed by a final byte
    task automatic enc_stream(input int len, input bit quiet);
        int         k;
        int         r;
        logic [7:0] b;
        logic       lst;
        bit         close;
        close = ($urandom_range(0, 4) != 0);
        for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                b = 8'h00;
            else if (r == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            lst = (k == len - 1) ? close : ($urandom_range(0, 24) == 0);
            send_item(b, lst, 1'b0, 3'd0, '0);
            pace(quiet);
        end
    endtask

    // Mostly well-formed text: groups, line breaks between them, padded tail,
    // with an occasional stray byte
    task automatic dec_stream(input int groups, input bit quiet);
        int         g;
        int         j;
        int         kind;
        int         nch;
        logic [7:0] grp [4];
        logic       lst;
        for (g = 0; g < groups; g++) begin
            if (g > 0 && $urandom_range(0, 4) == 0) begin
                send_item($urandom_range(0, 1) ? b64c_pkg::CHAR_CR : b64c_pkg::CHAR_LF,
                          1'b0, 1'b0, 3'd0, '0);
                pace(quiet);
            end
            // 0 full+last, 1 two pads, 2 one pad, 3 open, 4 short tail
            kind = (g == groups - 1) ? $urandom_range(0, 4) : 3;
            nch  = 4;
            for (j = 0; j < 4; j++) begin
                if ($urandom_range(0, 15) == 0)
                    grp[j] = 8'($urandom_range(0, 255));
                else
                    grp[j] = b64_alpha[$urandom_range(0, 63)];
            end
            case (kind)
                1:
                begin
                    grp[2] = b64c_pkg::CHAR_PAD;
                    grp[3] = b64c_pkg::CHAR_PAD;
                end
                2: grp[3] = b64c_pkg::CHAR_PAD;
                4: nch = $urandom_range(1, 3);
                default: ;
            endcase
            for (j = 0; j < nch; j++) begin
                lst = (j == nch - 1) && (kind != 3);
                send_item(grp[j], lst, 1'b0, 3'd0, '0);
                pace(quiet);
            end
        end
    endtask

    // Stimulus
    initial
    begin
        string abc;
        int    i;
        logic  m;
        bit    quiet;
        abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        for (i = 0; i < 256; i++)
            b64_value[i] = 8'hFF;
        for (i = 0; i < 64; i++) begin
            b64_alpha[i]      = abc[i];
            b64_value[abc[i]] = 8'(i);
        end
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        data_in    = '0;
        last_in    = 1'b0;
        in_up      = 1'b0;
        miss_cnt   = 0;
        items_sent = 0;
        cfg_mode   = b64c_pkg::MODE_RESET;
        cfg_lf_en  = b64c_pkg::LINE_BREAK_RESET;
        cfg_grps   = b64c_pkg::LINE_GRPS_RESET;
        grp_pos    = 2'd0;
        held       = 8'd0;
        line_cnt   = 8'd0;

        dir_rows = '{
            row_chk(8'hFF, 1'b1, 3'd4, {"/w==", 8'h00}),
            row_chk(8'h00, 1'b1, 3'd4, {"AA==", 8'h00}),
            row_reg(b64c_pkg::CFG_LINE_GRPS, 8'd1),
            row_item(8'h00, 1'b0),
            row_item(8'hFF, 1'b0),
            row_item(8'h80, 1'b0),
            row_chk("M", 1'b1, 3'd5, {"TQ==", b64c_pkg::CHAR_LF}),
            row_item("M", 1'b0),
            row_item("a", 1'b0),
            row_item("n", 1'b0),
            row_reg(b64c_pkg::CFG_LINE_BREAK, 8'd0),
            row_reg(b64c_pkg::CFG_LINE_GRPS, 8'd255),
            row_item(8'hA5, 1'b0),
            row_item(8'h5A, 1'b1),
            row_reg(b64c_pkg::CFG_MODE, {7'd0, b64c_pkg::MODE_DECODE}),
            row_item("T", 1'b0),
            row_item("W", 1'b0),
            row_item("F", 1'b0),
            row_item("u", 1'b0),
            row_item(b64c_pkg::CHAR_CR, 1'b0),
            row_item(b64c_pkg::CHAR_LF, 1'b0),
            row_item("T", 1'b0),
            row_item("Q", 1'b0),
            row_chk(b64c_pkg::CHAR_PAD, 1'b0, 3'd0, '0),
            row_chk(b64c_pkg::CHAR_PAD, 1'b1, 3'd0, '0),
            row_item(b64c_pkg::CHAR_PAD, 1'b0),
            row_item(b64c_pkg::CHAR_LF, 1'b0),
            row_item(8'hFF, 1'b0),
            row_reg(b64c_pkg::CFG_MODE, {7'd0, b64c_pkg::MODE_ENCODE}),
            row_item(8'h3C, 1'b1)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                write_reg(dir_rows[r].idx, dir_rows[r].d);
            else begin
                send_item(dir_rows[r].d, dir_rows[r].l, dir_rows[r].typed,
                          dir_rows[r].n, dir_rows[r].e);
                pace(1'b0);
            end
        end

        // Long encode run first, so the output hold-off backs up the block
        write_reg(b64c_pkg::CFG_LINE_BREAK, 8'd1);
        write_reg(b64c_pkg::CFG_LINE_GRPS, 8'd3);
        enc_stream(30, 1'b0);

        // Random phases, each starting from an idle block
        while (items_sent < DIR_ITEMS + RAND_ITEMS) begin
            m = 1'($urandom_range(0, 1));
            write_reg(b64c_pkg::CFG_MODE, {7'd0, m});
            if ($urandom_range(0, 2) != 0)
                write_reg(b64c_pkg::CFG_LINE_BREAK, {7'd0, ($urandom_range(0, 3) != 0)});
            if ($urandom_range(0, 2) != 0)
                write_reg(b64c_pkg::CFG_LINE_GRPS, pick_grps());
            quiet = ($urandom_range(0, 3) == 0);
            if (cfg_mode == b64c_pkg::MODE_ENCODE)
                enc_stream($urandom_range(3, 30), quiet);
            else
                dec_stream($urandom_range(1, 8), quiet);
        end

        drop_in();
        while (due_syms.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (miss_cnt == 0 && due_syms.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Output side: random stalls plus one long hold-off
    initial
    begin
        int taken;
        int stall_left;
        int go_left;
        bit held_once;
        taken      = 0;
        stall_left = 0;
        go_left    = 0;
        held_once  = 1'b0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!held_once && taken >= HOLD_AFTER) begin
                held_once  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (go_left > 0)
                    go_left--;
                else begin
                    go_left    = $urandom_range(1, 16);
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic report_miss(input string what, input logic [7:0] want, input logic [7:0] got);
        miss_cnt++;
        if (miss_cnt <= 10)
            $display("%t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Scoreboard: each accepted output against the oldest expected symbol
    always @(posedge clk)
    begin
        sym_t want;
        if (rst_n && out_valid && out_ready) begin
            if (due_syms.size() == 0)
                report_miss("output with nothing expected", 8'h00, data_out);
            else begin
                want = due_syms.pop_front();
                if (data_out !== want.data)
                    report_miss("data_out", want.data, data_out);
                if (last_out !== want.last)
                    report_miss("last_out", {7'd0, want.last}, {7'd0, last_out});
            end
        end
    end

    // Watchdog: too long without any input, output or configuration handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hdl/b64c_pkg.sv
hdl/base64_codec.sv
tb/tb_top.sv
